// File: rtl/core/npt_pkg.sv
`default_nettype none

package npt_pkg;

    // Default sizes of the table.
    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_MAX_DIMS   = 6;
    localparam int DEF_COORD_BITS = 16;

    // Fixed field widths of the item ports.
    localparam int IN_AXES     = 6;
    localparam int IN_COORD_W  = 16;
    localparam int EXT_COORD_W = 24;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int OUT_IDX_W   = 10;
    localparam int DIMS_W      = 3;

    localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd6;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic        [OP_W-1:0]       operation;
        logic signed [IN_COORD_W-1:0] coord_0;
        logic signed [IN_COORD_W-1:0] coord_1;
        logic signed [IN_COORD_W-1:0] coord_2;
        logic signed [IN_COORD_W-1:0] coord_3;
        logic signed [IN_COORD_W-1:0] coord_4;
        logic signed [IN_COORD_W-1:0] coord_5;
    } req_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] point_index;
        logic [STATUS_W-1:0]  status;
    } rsp_t;

    // Marks that travel with one row read through the distance pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } scan_tag_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/npt_ram.sv
`default_nettype none

module npt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/npt_dist.sv
`default_nettype none

module npt_dist
    import npt_pkg::*;
#(
    parameter int MAX_DIMS   = DEF_MAX_DIMS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int IDX_W      = 10
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [MAX_DIMS*COORD_BITS-1:0]        row,
    input  wire logic [MAX_DIMS*COORD_BITS-1:0]        query,
    input  wire logic [MAX_DIMS-1:0]                   lane_en,
    input  wire scan_tag_t                             tag_in,
    input  wire logic [IDX_W-1:0]                      idx_in,
    output logic [2*COORD_BITS+$clog2(MAX_DIMS)-1:0]   sum_out,
    output scan_tag_t                                  tag_out,
    output logic [IDX_W-1:0]                           idx_out
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + $clog2(MAX_DIMS);

    logic [SQ_W-1:0]  sq_next [MAX_DIMS];
    logic [SQ_W-1:0]  sq_reg  [MAX_DIMS];
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_reg;
    scan_tag_t        tag_a_reg;
    scan_tag_t        tag_b_reg;
    logic [IDX_W-1:0] idx_a_reg;
    logic [IDX_W-1:0] idx_b_reg;

    // One squaring lane per axis; axes that are switched off add nothing.
    always_comb
    begin
        logic signed [COORD_BITS:0]     diff;
        logic signed [2*COORD_BITS+1:0] prod;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            diff = $signed({row[k*COORD_BITS+COORD_BITS-1], row[k*COORD_BITS +: COORD_BITS]})
                 - $signed({query[k*COORD_BITS+COORD_BITS-1],
                            query[k*COORD_BITS +: COORD_BITS]});
            prod = diff * diff;
            sq_next[k] = lane_en[k] ? prod[SQ_W-1:0] : '0;
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            sum_next = sum_next + SUM_W'(sq_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            sq_reg[k] <= sq_next[k];
        end
        sum_reg   <= sum_next;
        idx_a_reg <= idx_in;
        idx_b_reg <= idx_a_reg;
    end

    assign sum_out = sum_reg;
    assign tag_out = tag_b_reg;
    assign idx_out = idx_b_reg;

endmodule

`default_nettype wire

// File: rtl/core/nearest_point_table.sv
// Insert, clear and unused operations: the result is registered from the transfer itself.
// Query: the stored points are read in order, then pass the memory read register and the
// distance pipeline's squaring and summing registers; the single read port of the point
// memory delivers one point per cycle. One item is in work at a time; the next is taken
// once its result sits in the output register, not while it waits in the slot behind it.
// Reset clears the point count, sets dims_in_use to 6 and empties the result registers.
`default_nettype none

module nearest_point_table
    import npt_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int MAX_DIMS   = DEF_MAX_DIMS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire req_t              req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output rsp_t                   rsp,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [DIMS_W-1:0] cfg_data
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int ROW_W = MAX_DIMS * COORD_BITS;
    localparam int SUM_W = 2 * COORD_BITS + $clog2(MAX_DIMS);

    state_t            state_reg;
    state_t            state_next;
    logic [DIMS_W-1:0] dims_in_use_reg;
    logic [CW-1:0]     count_reg;
    logic [AW-1:0]     scan_addr_reg;
    logic [ROW_W-1:0]  query_reg;
    logic [SUM_W-1:0]  best_reg;
    logic [AW-1:0]     best_idx_reg;
    scan_tag_t         rd_tag_reg;
    scan_tag_t         rd_tag_next;
    logic [AW-1:0]     rd_idx_reg;
    rsp_t              rsp_reg;
    logic              rsp_valid_reg;
    rsp_t              pend_reg;
    logic              pend_valid_reg;

    logic signed [IN_COORD_W-1:0] in_axis [IN_AXES];
    logic [ROW_W-1:0]  point_row;
    logic [MAX_DIMS-1:0] lane_en;
    logic              req_accept;
    logic              table_full;
    logic              issue_last;
    logic              rd_en;
    logic              ram_we;
    logic              fin;
    rsp_t              fin_data;
    logic              out_free;
    logic [ROW_W-1:0]  rd_row;
    logic [SUM_W-1:0]  sum_out;
    scan_tag_t         tag_out;
    logic [AW-1:0]     idx_out;
    logic              better;

    assign in_axis[0] = req.coord_0;
    assign in_axis[1] = req.coord_1;
    assign in_axis[2] = req.coord_2;
    assign in_axis[3] = req.coord_3;
    assign in_axis[4] = req.coord_4;
    assign in_axis[5] = req.coord_5;

    // A coordinate is sign extended and then cut to the stored width, so both wider and
    // narrower stored coordinates read the field the same way.
    for (genvar k = 0; k < MAX_DIMS; k++)
    begin : g_row
        if (k < IN_AXES)
        begin : g_in
            logic [EXT_COORD_W-1:0] ext;
            assign ext = {{(EXT_COORD_W-IN_COORD_W){in_axis[k][IN_COORD_W-1]}}, in_axis[k]};
            assign point_row[k*COORD_BITS +: COORD_BITS] = ext[COORD_BITS-1:0];
        end
        else
        begin : g_zero
            assign point_row[k*COORD_BITS +: COORD_BITS] = '0;
        end
        // Axis 0 is always compared; axes at or above MAX_DIMS do not exist.
        assign lane_en[k] = (k == 0) || (32'(k) < 32'(dims_in_use_reg));
    end

    assign cfg_ready  = 1'b1;
    assign req_stall  = (state_reg != ST_IDLE) || pend_valid_reg;
    assign req_accept = req_valid && !req_stall;
    assign table_full = (count_reg >= CW'(MAX_POINTS));
    assign issue_last = (CW'(scan_addr_reg) == (count_reg - CW'(1)));
    assign better     = tag_out.first || (sum_out < best_reg);
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    npt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (point_row),
        .rd_en   (rd_en),
        .rd_addr (scan_addr_reg),
        .rd_data (rd_row)
    );

    npt_dist #(
        .MAX_DIMS   (MAX_DIMS),
        .COORD_BITS (COORD_BITS),
        .IDX_W      (AW)
    ) u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .row     (rd_row),
        .query   (query_reg),
        .lane_en (lane_en),
        .tag_in  (rd_tag_reg),
        .idx_in  (rd_idx_reg),
        .sum_out (sum_out),
        .tag_out (tag_out),
        .idx_out (idx_out)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept && (req.operation == OP_QUERY) && (count_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (tag_out.valid && tag_out.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_we   = 1'b0;
        rd_en    = 1'b0;
        fin      = 1'b0;
        fin_data = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    unique case (req.operation)
                        OP_INSERT:
                        begin
                            fin = 1'b1;
                            if (table_full)
                            begin
                                fin_data.status = STAT_FULL;
                            end
                            else
                            begin
                                ram_we               = 1'b1;
                                fin_data.point_index = OUT_IDX_W'(count_reg);
                            end
                        end
                        OP_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                fin             = 1'b1;
                                fin_data.status = STAT_EMPTY;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_en = 1'b1;
            end
            ST_DRAIN:
            begin
                if (tag_out.valid && tag_out.last)
                begin
                    fin                  = 1'b1;
                    fin_data.point_index = OUT_IDX_W'(better ? idx_out : best_idx_reg);
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rd_tag_next.valid = rd_en;
        rd_tag_next.first = (scan_addr_reg == '0);
        rd_tag_next.last  = issue_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            dims_in_use_reg <= DIMS_RESET;
            count_reg       <= '0;
            rd_tag_reg      <= '0;
            rsp_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_tag_reg <= rd_tag_next;
            if (cfg_valid && cfg_ready)
            begin
                dims_in_use_reg <= cfg_data;
            end
            if (req_accept)
            begin
                if ((req.operation == OP_INSERT) && !table_full)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else if (req.operation == OP_CLEAR)
                begin
                    count_reg <= '0;
                end
            end
            // A finished result goes straight out when the output register frees up,
            // otherwise it waits one slot behind it.
            if (out_free)
            begin
                if (pend_valid_reg)
                begin
                    rsp_valid_reg  <= 1'b1;
                    pend_valid_reg <= fin;
                end
                else
                begin
                    rsp_valid_reg <= fin;
                end
            end
            else if (fin)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept && (req.operation == OP_QUERY))
        begin
            query_reg     <= point_row;
            scan_addr_reg <= '0;
        end
        else if (rd_en)
        begin
            scan_addr_reg <= scan_addr_reg + AW'(1);
        end
        rd_idx_reg <= scan_addr_reg;
        if (tag_out.valid && better)
        begin
            best_reg     <= sum_out;
            best_idx_reg <= idx_out;
        end
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                rsp_reg  <= pend_reg;
                pend_reg <= fin_data;
            end
            else if (fin)
            begin
                rsp_reg <= fin_data;
            end
        end
        else if (fin)
        begin
            pend_reg <= fin_data;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top
    import npt_pkg::*;
();

    localparam int MAX_TABLE   = DEF_MAX_POINTS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef logic signed [IN_COORD_W-1:0] coord_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    req_t              req       = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    rsp_t              rsp;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [DIMS_W-1:0] cfg_data  = '0;

    // Mirror of the table as the block should hold it after each accepted transfer.
    coord_t            point_mem [MAX_TABLE][IN_AXES];
    int                point_total  = 0;
    logic [DIMS_W-1:0] dims_setting = DIMS_RESET;

    req_t items_to_send [$];
    rsp_t answers_due [$];
    rsp_t oldest_answer;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    nearest_point_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** nearest_point_table: FAILED **");
            $finish;
        end
    end

    function automatic coord_t axis_of(input req_t item, input int k);
        case (k)
            0:       return item.coord_0;
            1:       return item.coord_1;
            2:       return item.coord_2;
            3:       return item.coord_3;
            4:       return item.coord_4;
            default: return item.coord_5;
        endcase
    endfunction

    function automatic req_t with_axis(input req_t item, input int k, input coord_t value);
        req_t updated;
        updated = item;
        case (k)
            0:       updated.coord_0 = value;
            1:       updated.coord_1 = value;
            2:       updated.coord_2 = value;
            3:       updated.coord_3 = value;
            4:       updated.coord_4 = value;
            default: updated.coord_5 = value;
        endcase
        return updated;
    endfunction

    // Applies one accepted item to the mirror and returns the answer it must produce.
    function automatic rsp_t table_answer(input req_t item);
        rsp_t            answer;
        int              axes;
        longint          diff;
        longint unsigned sq_dist;
        longint unsigned best_sq;
        answer  = '0;
        best_sq = '0;
        if (dims_setting == 0)
            axes = 1;
        else if (dims_setting > DEF_MAX_DIMS)
            axes = DEF_MAX_DIMS;
        else
            axes = int'(dims_setting);
        case (item.operation)
            OP_INSERT:
            begin
                if (point_total >= MAX_TABLE)
                    answer.status = STAT_FULL;
                else
                begin
                    for (int k = 0; k < IN_AXES; k++)
                        point_mem[point_total][k] = axis_of(item, k);
                    answer.point_index = OUT_IDX_W'(point_total);
                    point_total++;
                end
            end
            OP_QUERY:
            begin
                if (point_total == 0)
                    answer.status = STAT_EMPTY;
                else
                begin
                    for (int i = 0; i < point_total; i++)
                    begin
                        sq_dist = 0;
                        for (int k = 0; k < axes; k++)
                        begin
                            diff = longint'(point_mem[i][k]) - longint'(axis_of(item, k));
                            sq_dist += diff * diff;
                        end
                        // Strict compare, so the earliest of equal distances wins.
                        if (i == 0 || sq_dist < best_sq)
                        begin
                            best_sq            = sq_dist;
                            answer.point_index = OUT_IDX_W'(i);
                        end
                    end
                end
            end
            OP_CLEAR:
                point_total = 0;
            default:
                ;
        endcase
        return answer;
    endfunction

    // Sender: presents queued items, holding each one until its transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                answers_due.push_back(table_answer(req));
            if (!req_valid || !req_stall)
            begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req       <= items_to_send.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (answers_due.size() == 0)
            begin
                $error("result with nothing expected: point_index %0d, status %0d",
                       rsp.point_index, rsp.status);
                fail_count++;
            end
            else
            begin
                oldest_answer = answers_due.pop_front();
                if (rsp.point_index !== oldest_answer.point_index)
                begin
                    $error("point_index: expected %0d, got %0d",
                           oldest_answer.point_index, rsp.point_index);
                    fail_count++;
                end
                if (rsp.status !== oldest_answer.status)
                begin
                    $error("status: expected %0d, got %0d", oldest_answer.status, rsp.status);
                    fail_count++;
                end
            end
        end
    end

    function automatic coord_t pick_coord();
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return coord_t'($urandom_range(64)) - 16'sd32;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic req_t random_point(input logic [OP_W-1:0] op);
        req_t item;
        item           = '0;
        item.operation = op;
        for (int k = 0; k < IN_AXES; k++)
            item = with_axis(item, k, pick_coord());
        return item;
    endfunction

    // A point within a box of the given half width around a stored point.
    function automatic req_t near_point(input logic [OP_W-1:0] op, input int idx,
                                        input int spread);
        req_t   item;
        coord_t offset;
        item           = '0;
        item.operation = op;
        for (int k = 0; k < IN_AXES; k++)
        begin
            offset = coord_t'($urandom_range(2 * spread)) - coord_t'(spread);
            item   = with_axis(item, k, point_mem[idx][k] + offset);
        end
        return item;
    endfunction

    function automatic req_t striped_point(input logic [OP_W-1:0] op, input coord_t even_value,
                                           input coord_t odd_value);
        req_t item;
        item           = '0;
        item.operation = op;
        for (int k = 0; k < IN_AXES; k++)
            item = with_axis(item, k, (k % 2 == 0) ? even_value : odd_value);
        return item;
    endfunction

    task automatic send_item(input req_t item);
        items_to_send.push_back(item);
        do
            @(negedge clk);
        while (items_to_send.size() != 0);
    endtask

    task automatic hold_until_answered();
        while (items_to_send.size() != 0 || req_valid || answers_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_dims(input logic [DIMS_W-1:0] value);
        hold_until_answered();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid    <= 1'b0;
        dims_setting = value;
        @(negedge clk);
    endtask

    task automatic test_empty_and_unused();
        send_item(random_point(OP_QUERY));
        send_item(random_point(OP_CLEAR));
        send_item(random_point(OP_UNUSED));
    endtask

    // Runs with the reset axis count, so all six axes count.
    task automatic test_extreme_points();
        send_item(striped_point(OP_INSERT, 16'sh7FFF, 16'sh7FFF));
        send_item(striped_point(OP_INSERT, 16'sh8000, 16'sh8000));
        send_item(striped_point(OP_INSERT, 16'sh0000, 16'sh0000));
        send_item(striped_point(OP_INSERT, 16'sh7FFF, 16'sh7FFF));
        send_item(striped_point(OP_INSERT, 16'sh7FFF, 16'sh8000));
        send_item(striped_point(OP_QUERY, 16'sh7FFF, 16'sh7FFF));
        send_item(striped_point(OP_QUERY, 16'sh8000, 16'sh8000));
        send_item(striped_point(OP_QUERY, 16'shFFFF, 16'shFFFF));
        send_item(striped_point(OP_QUERY, 16'sh8000, 16'sh7FFF));
        send_item(striped_point(OP_UNUSED, 16'sh7FFF, 16'sh7FFF));
        send_item(striped_point(OP_QUERY, 16'sh0000, 16'sh0000));
        send_item(random_point(OP_CLEAR));
        send_item(striped_point(OP_QUERY, 16'sh0000, 16'sh0000));
    endtask

    // The first point matches the origin on axis 0 but is far on the odd axes, the second
    // is close on all axes, so the winner flips with the number of axes compared.
    task automatic test_axis_count();
        send_item(random_point(OP_CLEAR));
        send_item(striped_point(OP_INSERT, 16'sd0, 16'sd100));
        send_item(with_axis(striped_point(OP_INSERT, 16'sd0, 16'sd0), 0, 16'sd1));
        write_dims(3'd1);
        send_item(striped_point(OP_QUERY, 16'sd0, 16'sd0));
        write_dims(3'd0);
        send_item(striped_point(OP_QUERY, 16'sd0, 16'sd0));
        write_dims(3'd7);
        send_item(striped_point(OP_QUERY, 16'sd0, 16'sd0));
    endtask

    task automatic test_full_table();
        write_dims(DIMS_W'($urandom_range(7)));
        send_item(random_point(OP_CLEAR));
        repeat (MAX_TABLE)
            send_item(random_point(OP_INSERT));
        repeat (2)
            send_item(random_point(OP_INSERT));
        send_item(random_point(OP_UNUSED));
        // The last point must be in the mirror before it is copied into a query.
        hold_until_answered();
        send_item(near_point(OP_QUERY, MAX_TABLE - 1, 0));
        send_item(random_point(OP_QUERY));
        send_item(random_point(OP_CLEAR));
        send_item(random_point(OP_QUERY));
    endtask

    // Episodes of inserts followed by queries aimed at stored points, with duplicates
    // for ties, the odd unused operation and the odd query straight after a clear.
    task automatic test_random_traffic(input int item_goal);
        int sent;
        int batch;
        int kind;
        sent = 0;
        while (sent < item_goal)
        begin
            if ($urandom_range(3) == 0)
                write_dims(DIMS_W'($urandom_range(7)));
            if ($urandom_range(2) != 0)
            begin
                send_item(random_point(OP_CLEAR));
                sent++;
            end
            batch = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(12, 1);
            repeat (batch)
            begin
                kind = $urandom_range(5);
                if (point_total != 0 && kind == 0)
                    send_item(near_point(OP_INSERT, $urandom_range(point_total - 1), 0));
                else if (point_total != 0 && kind == 1)
                    send_item(near_point(OP_INSERT, $urandom_range(point_total - 1), 50));
                else
                    send_item(random_point(OP_INSERT));
                sent++;
            end
            batch = $urandom_range(8, 2);
            repeat (batch)
            begin
                kind = $urandom_range(3);
                if (point_total == 0 || kind == 3)
                    send_item(random_point(OP_QUERY));
                else
                    send_item(near_point(OP_QUERY, $urandom_range(point_total - 1),
                                         (kind == 2) ? 0 : 300));
                sent++;
            end
            if ($urandom_range(4) == 0)
                send_item(random_point(OP_UNUSED));
            if ($urandom_range(7) == 0)
            begin
                send_item(random_point(OP_CLEAR));
                send_item(random_point(OP_QUERY));
                sent += 2;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 10;
        stall_pct     = 83;
        test_empty_and_unused();
        test_extreme_points();
        test_axis_count();
        write_dims(3'd1);
        test_random_traffic(195);

        hold_until_answered();
        send_idle_pct = 83;
        stall_pct     = 10;
        test_full_table();
        write_dims(DIMS_W'(DEF_MAX_DIMS));
        test_random_traffic(195);

        hold_until_answered();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_dims(3'd3);
        test_random_traffic(195);

        hold_until_answered();
        repeat (point_total + 8) @(negedge clk);
        if (fail_count == 0)
            $display("** nearest_point_table: PASSED **");
        else
            $display("** nearest_point_table: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/npt_pkg.sv
rtl/core/npt_ram.sv
rtl/core/npt_dist.sv
rtl/core/nearest_point_table.sv
tb/tb_top.sv
